FILE: hdl/sinc3_bitstream_decimator_unit_defines.svh
// ----------------------------------------------------------------------------
// sinc3 decimator assertion macros
// Concurrent check helpers, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SINC3_BITSTREAM_DECIMATOR_UNIT_DEFINES_SVH
`define SINC3_BITSTREAM_DECIMATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SINC3_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define SINC3_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);
`else
`define SINC3_ASSERT_IMP(lbl, pre, post, msg)
`define SINC3_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: hdl/sinc3_pkg.sv
// ----------------------------------------------------------------------------
// sinc3 decimator package
// Shared widths, reset value and the queue status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sinc3_pkg;

  localparam int RATIO_W     = 11;
  localparam int PHASE_W     = 10;
  localparam int RATIO_MAX   = 1024;
  localparam int OUT_W       = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 11'd32;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: hdl/sinc3_front.sv
// ----------------------------------------------------------------------------
// sinc3 front end
// Integrator cascade and phase counter; queues the third integrator on the
// last phase of each group.
// ----------------------------------------------------------------------------
`default_nettype none

module sinc3_front #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         clear,
  input  wire logic [sinc3_pkg::RATIO_W-1:0] ratio,
  input  wire logic                         in_valid,
  input  wire logic                         in_bit,
  output logic                              in_ready,
  input  wire sinc3_pkg::queue_status_t     status,
  output logic                              push,
  output logic [ACC_WIDTH-1:0]              push_data
);
  import sinc3_pkg::*;

  logic [ACC_WIDTH-1:0] integrator_one;
  logic [ACC_WIDTH-1:0] integrator_two;
  logic [ACC_WIDTH-1:0] integrator_three;
  logic [PHASE_W-1:0]   phase_count;
  logic [PHASE_W-1:0]   phase_last;
  logic [RATIO_W-1:0]   ratio_dec;
  logic [ACC_WIDTH-1:0] step_value;
  logic                 accept;
  logic                 last;

  assign ratio_dec = ratio - RATIO_W'(1);

  always_comb begin
    priority if (ratio == '0) begin
      phase_last = '0;
    end else if (ratio > RATIO_W'(RATIO_MAX)) begin
      phase_last = PHASE_W'(RATIO_MAX - 1);
    end else begin
      phase_last = ratio_dec[PHASE_W-1:0];
    end
  end

  // bit 0 maps to +1, bit 1 to all ones (-1)
  assign step_value = {{(ACC_WIDTH-1){in_bit}}, 1'b1};

  // hold off input while the queue is full or a ratio write clears the filter
  assign in_ready  = !status.full && !clear;
  assign accept    = in_valid && in_ready;
  assign last      = phase_count >= phase_last;
  assign push      = accept && last && !clear;
  assign push_data = integrator_three;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      integrator_one   <= '0;
      integrator_two   <= '0;
      integrator_three <= '0;
      phase_count      <= '0;
    end else if (accept) begin
      integrator_three <= integrator_three + integrator_two;
      integrator_two   <= integrator_two + integrator_one;
      integrator_one   <= integrator_one + step_value;
      if (last) begin
        phase_count <= '0;
      end else begin
        phase_count <= phase_count + PHASE_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sinc3_queue.sv
// ----------------------------------------------------------------------------
// sinc3 sample queue
// Short FIFO of integrator snapshots between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sinc3_queue #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     clear,
  input  wire logic                     push,
  input  wire logic [ACC_WIDTH-1:0]     push_data,
  input  wire logic                     pop,
  output logic [ACC_WIDTH-1:0]          pop_data,
  output sinc3_pkg::queue_status_t      status
);
  import sinc3_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ACC_WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign status.full  = count == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sinc3_back.sv
// ----------------------------------------------------------------------------
// sinc3 back end
// Comb cascade on queued snapshots and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sinc3_back #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear,
  input  wire sinc3_pkg::queue_status_t   status,
  input  wire logic [ACC_WIDTH-1:0]       pop_data,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [sinc3_pkg::OUT_W-1:0]     out_data
);
  import sinc3_pkg::*;

  logic [ACC_WIDTH-1:0] integrator_three_delayed;
  logic [ACC_WIDTH-1:0] comb_one;
  logic [ACC_WIDTH-1:0] comb_one_delayed;
  logic [ACC_WIDTH-1:0] comb_two;
  logic [ACC_WIDTH-1:0] comb_two_delayed;
  logic [ACC_WIDTH-1:0] third;
  logic [OUT_W-1:0]     third_out;

  assign pop   = !status.empty && (!out_valid || out_ready) && !clear;
  assign third = comb_two - comb_two_delayed;

  generate
    if (ACC_WIDTH >= OUT_W) begin : g_trunc
      assign third_out = third[OUT_W-1:0];
    end else begin : g_sext
      assign third_out = {{(OUT_W-ACC_WIDTH){third[ACC_WIDTH-1]}}, third};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      integrator_three_delayed <= '0;
      comb_one                 <= '0;
      comb_one_delayed         <= '0;
      comb_two                 <= '0;
      comb_two_delayed         <= '0;
    end else if (pop) begin
      comb_two_delayed         <= comb_two;
      comb_two                 <= comb_one - comb_one_delayed;
      comb_one_delayed         <= comb_one;
      comb_one                 <= pop_data - integrator_three_delayed;
      integrator_three_delayed <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= third_out;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sinc3_bitstream_decimator_unit.sv
// ----------------------------------------------------------------------------
// sinc3 bitstream decimator
// Third-order CIC decimator for a one-bit sigma-delta stream.
// ----------------------------------------------------------------------------
//  channel   dir  signals                      payload
//  s_*       in   s_tvalid s_tready s_tdata    [0] modulator_bit, [7:1] zero
//  m_*       out  m_tvalid m_tready m_tdata    [31:0] decimated_value
//  cfg_*     in   cfg_valid cfg_ready cfg_data [10:0] decimation_ratio
//
//  One modulator bit per cycle while s_tready is high, set by the integrator
//  cascade (one add per stage per cycle). One result per decimation_ratio bits
//  (0 as 1, max 1024), each queued and then registered onto m_tdata. Reset:
//  ratio 32, all filter state zero. A ratio write clears the filter and holds
//  s_tready low while offered. A two-entry queue between integrators and combs
//  absorbs output stalls; otherwise s_tready drops only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sinc3_bitstream_decimator_unit_defines.svh"

module sinc3_bitstream_decimator_unit #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [0] modulator_bit
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [sinc3_pkg::OUT_W-1:0]        m_tdata,   // [31:0] decimated_value
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sinc3_pkg::RATIO_W-1:0] cfg_data   // [10:0] decimation_ratio
);
  import sinc3_pkg::*;

  logic [RATIO_W-1:0]   decimation_ratio;
  logic                 clear;
  logic                 push;
  logic [ACC_WIDTH-1:0] push_data;
  logic                 pop;
  logic [ACC_WIDTH-1:0] pop_data;
  queue_status_t        status;

  assign cfg_ready = 1'b1;
  assign clear     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_ratio <= RATIO_RESET;
    end else if (clear) begin
      decimation_ratio <= cfg_data;
    end
  end

  sinc3_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .ratio     (decimation_ratio),
    .in_valid  (s_tvalid),
    .in_bit    (s_tdata[0]),
    .in_ready  (s_tready),
    .status    (status),
    .push      (push),
    .push_data (push_data)
  );

  sinc3_queue #(.ACC_WIDTH(ACC_WIDTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (status)
  );

  sinc3_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .status    (status),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  `SINC3_ASSERT_IMP(a_no_overflow, push, !status.full, "push into full queue")
  `SINC3_ASSERT_IMP(a_no_underflow, pop, !status.empty, "pop from empty queue")
  `SINC3_ASSERT_NEXT(a_clear_flushes, clear || rst, !m_tvalid && status.empty, "not cleared")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sinc3 bitstream decimator testbench
// Streams modulator bits through the decimator while both sides idle at
// random, predicts or pins every decimated sample and checks the samples in order.
// ----------------------------------------------------------------------------

module tb_top;
  import sinc3_pkg::*;

  localparam int ACC_W         = 32;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 10;
  localparam int DENS_WANDER   = 101;
  localparam int FIXED_PHASES  = 7;
  localparam int ALL_PHASES    = 10;

  typedef struct packed {
    logic               wr_ratio;
    logic [RATIO_W-1:0] ratio;
    logic               mbit;
    logic               pinned;
    logic [OUT_W-1:0]   pin;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RATIO_W-1:0] cfg_data;

  // filter model state
  logic [RATIO_W-1:0] ratio_q;
  logic [ACC_W-1:0]   integ1, integ2, integ3, integ3_dly;
  logic [ACC_W-1:0]   comb1, comb1_dly, comb2, comb2_dly;
  logic [PHASE_W-1:0] phase_q;

  logic [OUT_W-1:0]   decimated_q[$];
  int                 errors = 0;
  int                 cycles = 0;
  bit                 gaps_on;
  logic               pin_en;
  logic [OUT_W-1:0]   pin_value;

  // after reset: partial group at ratio 32, then ratio 1 and ratio 0 (acts as 1)
  // from a cleared filter, where a constant input settles after five samples
  stim_row_t plan [23] = '{
    '{1'b0, 11'd0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 11'd0, 1'b1, 1'b0, 32'd0},
    '{1'b0, 11'd0, 1'b0, 1'b0, 32'd0},
    '{1'b1, 11'd1, 1'b0, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b0, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b0, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b0, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b0, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b0, 1'b1, 32'd1},
    '{1'b0, 11'd0, 1'b0, 1'b1, 32'd1},
    '{1'b1, 11'd0, 1'b1, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b1, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b1, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b1, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b1, 1'b1, 32'd0},
    '{1'b0, 11'd0, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, 11'd0, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{1'b1, 11'd2, 1'b1, 1'b0, 32'd0},
    '{1'b0, 11'd0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 11'd0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 11'd0, 1'b1, 1'b0, 32'd0},
    '{1'b0, 11'd0, 1'b1, 1'b0, 32'd0},
    '{1'b0, 11'd0, 1'b0, 1'b0, 32'd0}
  };

  int phase_ratio   [FIXED_PHASES] = '{32, 1, 2047, 3, 0, 1024, 7};
  int phase_items   [FIXED_PHASES] = '{120, 80, 200, 90, 60, 60, 100};
  int phase_density [FIXED_PHASES] = '{DENS_WANDER, DENS_WANDER, 100, DENS_WANDER,
                                       50, 0, DENS_WANDER};

  sinc3_bitstream_decimator_unit #(
    .ACC_WIDTH(ACC_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [0] modulator_bit
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [31:0] decimated_value
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)    // [10:0] decimation_ratio
  );

  always #5 clk = ~clk;

  function automatic void cic_clear();
    integ1     = '0;
    integ2     = '0;
    integ3     = '0;
    integ3_dly = '0;
    comb1      = '0;
    comb1_dly  = '0;
    comb2      = '0;
    comb2_dly  = '0;
    phase_q    = '0;
  endfunction

  // advance the filter by one bit; returns 1 when a decimated sample falls out
  function automatic bit cic_advance(input logic mbit, output logic [OUT_W-1:0] sample);
    logic [ACC_W-1:0]   delta;
    logic [ACC_W-1:0]   third;
    logic [RATIO_W-1:0] eff;
    bit                 fire;
    delta  = mbit ? {ACC_W{1'b1}} : ACC_W'(1);
    sample = '0;
    fire   = 1'b0;
    if (ratio_q == '0) begin
      eff = RATIO_W'(1);
    end else if (ratio_q > RATIO_MAX) begin
      eff = RATIO_W'(RATIO_MAX);
    end else begin
      eff = ratio_q;
    end
    if ({1'b0, phase_q} < eff - 1'b1) begin
      phase_q = phase_q + 1'b1;
    end else begin
      // combs see the third integrator before this bit lands
      third      = comb2 - comb2_dly;
      comb2_dly  = comb2;
      comb2      = comb1 - comb1_dly;
      comb1_dly  = comb1;
      comb1      = integ3 - integ3_dly;
      integ3_dly = integ3;
      phase_q    = '0;
      sample     = third;
      fire       = 1'b1;
    end
    integ3 = integ3 + integ2;
    integ2 = integ2 + integ1;
    integ1 = integ1 + delta;
    return fire;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_bit(input logic b, input logic pinned, input logic [OUT_W-1:0] pin);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid  = 1'b1;
    s_tdata   = {7'd0, b};
    pin_en    = pinned;
    pin_value = pin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // write the ratio only once the decimator has gone quiet
  task automatic write_ratio(input logic [RATIO_W-1:0] r);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (decimated_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    logic [OUT_W-1:0] predicted;
    logic [OUT_W-1:0] want;
    if (rst) begin
      ratio_q = RATIO_RESET;
      cic_clear();
      decimated_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        ratio_q = cfg_data;
        cic_clear();
      end
      if (s_tvalid && s_tready) begin
        if (cic_advance(s_tdata[0], predicted)) begin
          decimated_q.push_back(pin_en ? pin_value : predicted);
        end
      end
      if (m_tvalid && m_tready) begin
        if (decimated_q.size() == 0) begin
          $display("%0t: decimated_value %h with nothing expected", $time, m_tdata);
          errors++;
        end else begin
          want = decimated_q.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: decimated_value mismatch: expected %h, got %h",
                     $time, want, m_tdata);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL sinc3_bitstream_decimator_unit");
      $finish;
    end
  end

  // sink side: hold ready low for random stalls
  initial begin
    int stall;
    stall    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        stall    = pick_gap();
      end
    end
  end

  initial begin
    int ratio;
    int items;
    int dens_mode;
    int density;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    pin_en    = 1'b0;
    pin_value = '0;
    gaps_on   = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].wr_ratio) write_ratio(plan[i].ratio);
      send_bit(plan[i].mbit, plan[i].pinned, plan[i].pin);
    end

    for (int p = 0; p < ALL_PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        ratio     = phase_ratio[p];
        items     = phase_items[p];
        dens_mode = phase_density[p];
      end else begin
        ratio     = $urandom_range(2, 48);
        items     = 40;
        dens_mode = DENS_WANDER;
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      write_ratio(RATIO_W'(ratio));
      density = (dens_mode == DENS_WANDER) ? 50 : dens_mode;
      for (int n = 0; n < items; n++) begin
        // let the ones density drift like a slowly moving analog input
        if (dens_mode == DENS_WANDER && n % 32 == 0) density = $urandom_range(0, 100);
        send_bit($urandom_range(0, 99) < density, 1'b0, '0);
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (decimated_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sinc3_bitstream_decimator_unit");
    end else begin
      $display("FAIL sinc3_bitstream_decimator_unit");
    end
    $finish;
  end

endmodule
